FILE: rtl/core/i2a_pkg.sv
// Package for the integer-to-ASCII formatter: sizes, radix codes, ASCII constants
// and the digit glyph function. It depends on nothing else.
package i2a_pkg;

  localparam int unsigned VALUE_BITS = 64;   // bits of the value that take part
  localparam int unsigned MAX_WIDTH  = 64;   // largest honoured field width
  localparam int unsigned OUT_LIMIT  = 64;   // longest field emitted
  localparam int unsigned IN_BITS    = 64;   // width of the value port
  localparam int unsigned BCD_DIGITS = 20;   // decimal digits of a 64-bit number
  localparam int unsigned SR_BITS    = 4 * BCD_DIGITS;

  localparam logic [IN_BITS-1:0] VALUE_MASK = {IN_BITS{1'b1}} >> (IN_BITS - VALUE_BITS);

  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_UPPER = 8'h41;

  // What a character of the field is made of.
  typedef enum logic [1:0] {
    KIND_SIGN  = 2'd0,
    KIND_ZERO  = 2'd1,
    KIND_SPACE = 2'd2,
    KIND_DIGIT = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_NORM = 5'b00100,
    S_SIZE = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    if (d < 4'd10) begin
      g = ASCII_ZERO + {4'd0, d};
    end else begin
      g = ASCII_UPPER + {4'd0, d - 4'd10};
    end
    return g;
  endfunction

endpackage

FILE: rtl/core/integer_to_ascii_formatter.sv
// Integer-to-ASCII formatter: converts a number and emits its text one character a cycle.
// Depends on i2a_pkg.
//
// Pulse start_i while busy_o is low to hand over one item. Binary, octal and hex
// digits are loaded straight into an 80-bit digit shift register; decimal goes
// through a bit-serial double-dabble converter that takes one value bit a cycle.
// Leading zero digits are then shifted out one digit a cycle, a sizing step sets
// up the field, and the characters follow one per cycle on character_o with
// char_valid_o, the final one flagged by last_char_o. Results cannot be held off:
// take each character in the cycle it is shown. busy_o drops after the final
// character has been registered, so the next item may start while that character
// is shown.
module integer_to_ascii_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] value_i,
  input  logic [1:0]  base_select_i,
  input  logic        is_signed_i,
  input  logic [6:0]  field_width_i,
  input  logic        left_justify_i,
  input  logic        zero_pad_i,
  output logic        char_valid_o,
  output logic [7:0]  character_o,
  output logic        last_char_o
);
  import i2a_pkg::*;

  state_e state_q, state_d;

  logic [SR_BITS-1:0] sr_q, sr_d;
  logic [IN_BITS-1:0] bin_q, bin_d;
  logic [1:0]         base_q, base_d;
  logic               minus_q, minus_d;
  logic               ljust_q, ljust_d;
  logic               zpad_q, zpad_d;
  logic [6:0]         width_q, width_d;
  logic [6:0]         cnt_q, cnt_d;
  logic [6:0]         k_q, k_d;
  logic [6:0]         len_q, len_d;
  logic [6:0]         thr1_q, thr1_d;
  logic [6:0]         thr2_q, thr2_d;
  kind_e              kind0_q, kind0_d, kind1_q, kind1_d, kind2_q, kind2_d;

  logic               valid_d;
  logic [7:0]         char_d;
  logic               last_d;

  logic [IN_BITS-1:0] val_m;
  logic [IN_BITS-1:0] mag;
  logic               neg;
  logic [SR_BITS-1:0] adj;
  logic [3:0]         top_dig;
  logic [SR_BITS-1:0] sr_shift;
  logic [6:0]         body;
  logic [6:0]         pad;
  logic [6:0]         len0;
  kind_e              kind;

  // Magnitude of the incoming value.
  always_comb begin
    val_m = value_i & VALUE_MASK;
    neg   = is_signed_i & val_m[VALUE_BITS-1];
    mag   = neg ? ((~val_m + {{(IN_BITS-1){1'b0}}, 1'b1}) & VALUE_MASK) : val_m;
  end

  // Double-dabble correction: every BCD digit of five or more gets three added.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (sr_q[4*i +: 4] >= 4'd5) ? sr_q[4*i +: 4] + 4'd3 : sr_q[4*i +: 4];
    end
  end

  // Top digit and the register shifted by one digit, for the held radix.
  always_comb begin
    unique case (base_q)
      BASE_BIN: begin
        top_dig  = {3'd0, sr_q[SR_BITS-1]};
        sr_shift = {sr_q[SR_BITS-2:0], 1'b0};
      end
      BASE_OCT: begin
        top_dig  = {1'b0, sr_q[SR_BITS-1 -: 3]};
        sr_shift = {sr_q[SR_BITS-4:0], 3'd0};
      end
      default: begin
        top_dig  = sr_q[SR_BITS-1 -: 4];
        sr_shift = {sr_q[SR_BITS-5:0], 4'd0};
      end
    endcase
  end

  always_comb begin
    body = cnt_q + {6'd0, minus_q};
    pad  = (width_q > body) ? width_q - body : 7'd0;
    len0 = (width_q > body) ? width_q : body;
  end

  always_comb begin
    priority if (k_q < thr1_q) begin
      kind = kind0_q;
    end else if (k_q < thr2_q) begin
      kind = kind1_q;
    end else begin
      kind = kind2_q;
    end
  end

  always_comb begin
    state_d = state_q;
    sr_d    = sr_q;
    bin_d   = bin_q;
    base_d  = base_q;
    minus_d = minus_q;
    ljust_d = ljust_q;
    zpad_d  = zpad_q;
    width_d = width_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    len_d   = len_q;
    thr1_d  = thr1_q;
    thr2_d  = thr2_q;
    kind0_d = kind0_q;
    kind1_d = kind1_q;
    kind2_d = kind2_q;
    valid_d = 1'b0;
    char_d  = character_o;
    last_d  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          base_d  = base_select_i;
          minus_d = neg;
          ljust_d = left_justify_i;
          zpad_d  = zero_pad_i;
          width_d = (field_width_i > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : field_width_i;
          bin_d   = mag;
          k_d     = 7'd0;
          state_d = S_NORM;
          unique case (base_select_i)
            BASE_BIN: begin
              sr_d  = {mag, {(SR_BITS-IN_BITS){1'b0}}};
              cnt_d = 7'd64;
            end
            BASE_OCT: begin
              sr_d  = {2'b00, mag, {(SR_BITS-IN_BITS-2){1'b0}}};
              cnt_d = 7'd22;
            end
            BASE_DEC: begin
              sr_d    = '0;
              cnt_d   = 7'(BCD_DIGITS);
              state_d = S_CONV;
            end
            default: begin
              sr_d  = {mag, {(SR_BITS-IN_BITS){1'b0}}};
              cnt_d = 7'd16;
            end
          endcase
        end
      end
      S_CONV: begin
        sr_d  = {adj[SR_BITS-2:0], bin_q[IN_BITS-1]};
        bin_d = {bin_q[IN_BITS-2:0], 1'b0};
        k_d   = k_q + 7'd1;
        if (k_q == 7'(IN_BITS - 1)) begin
          k_d     = 7'd0;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (cnt_q > 7'd1 && top_dig == 4'd0) begin
          sr_d  = sr_shift;
          cnt_d = cnt_q - 7'd1;
        end else begin
          state_d = S_SIZE;
        end
      end
      S_SIZE: begin
        len_d = (len0 > 7'(OUT_LIMIT)) ? 7'(OUT_LIMIT) : len0;
        k_d   = 7'd0;
        if (ljust_q) begin
          thr1_d  = {6'd0, minus_q};
          thr2_d  = body;
          kind0_d = KIND_SIGN;
          kind1_d = KIND_DIGIT;
          kind2_d = KIND_SPACE;
        end else if (zpad_q) begin
          thr1_d  = {6'd0, minus_q};
          thr2_d  = {6'd0, minus_q} + pad;
          kind0_d = KIND_SIGN;
          kind1_d = KIND_ZERO;
          kind2_d = KIND_DIGIT;
        end else begin
          thr1_d  = pad;
          thr2_d  = pad + {6'd0, minus_q};
          kind0_d = KIND_SPACE;
          kind1_d = KIND_SIGN;
          kind2_d = KIND_DIGIT;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        valid_d = 1'b1;
        unique case (kind)
          KIND_SIGN:  char_d = ASCII_MINUS;
          KIND_ZERO:  char_d = ASCII_ZERO;
          KIND_SPACE: char_d = ASCII_SPACE;
          default: begin
            char_d = digit_glyph(top_dig);
            sr_d   = sr_shift;
          end
        endcase
        k_d = k_q + 7'd1;
        if (k_q == len_q - 7'd1) begin
          last_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      char_valid_o <= 1'b0;
      last_char_o  <= 1'b0;
      character_o  <= 8'd0;
    end else begin
      state_q      <= state_d;
      char_valid_o <= valid_d;
      last_char_o  <= last_d;
      character_o  <= char_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q    <= sr_d;
    bin_q   <= bin_d;
    base_q  <= base_d;
    minus_q <= minus_d;
    ljust_q <= ljust_d;
    zpad_q  <= zpad_d;
    width_q <= width_d;
    cnt_q   <= cnt_d;
    k_q     <= k_d;
    len_q   <= len_d;
    thr1_q  <= thr1_d;
    thr2_q  <= thr2_d;
    kind0_q <= kind0_d;
    kind1_q <= kind1_d;
    kind2_q <= kind2_d;
  end

  assign busy_o = (state_q != S_IDLE);

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not make the block busy");

  a_strobe_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> $past(busy_o))
    else $error("character shown without an item in progress");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_char_o |-> char_valid_o)
    else $error("final-character flag without a character");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> k_q < len_q)
    else $error("character index ran past the field length");

endmodule
